@@ hdl/cth_pkg.sv @@
// ----------------------------------------------------------------------------
// cth_pkg: shared types and constants of the crypt table string hash
// Seed constants, table generator constants, register map and queue entry.
// ----------------------------------------------------------------------------
package cth_pkg;

	localparam int BYTE_W       = 8;
	localparam int WORD_W       = 32;
	localparam int SECT_W       = 3;
	localparam int GEN_SECTIONS = 5;

	// running seeds
	localparam logic [WORD_W-1:0] SEED1_INIT = 32'h7FED7FED;
	localparam logic [WORD_W-1:0] SEED2_INIT = 32'hEEEEEEEE;
	localparam logic [WORD_W-1:0] SEED_INC   = 32'd3;
	localparam int                SEED_SHIFT = 5;

	// case folding, C locale
	localparam logic [BYTE_W-1:0] CHAR_LOWER_A = 8'h61;
	localparam logic [BYTE_W-1:0] CHAR_LOWER_Z = 8'h7A;
	localparam logic [BYTE_W-1:0] CASE_OFFSET  = 8'h20;

	// table generator: s = (s*125 + 3) mod 0x2AAAAB, done as three times-5 steps
	localparam int                LCG_W        = 22;
	localparam logic [LCG_W-1:0]  LCG_MOD      = 22'h2AAAAB;
	localparam logic [LCG_W-1:0]  LCG_SEED     = 22'h100001;
	localparam logic [1:0]        LCG_LAST_SUB = 2'd2;
	localparam logic [BYTE_W-1:0] INDEX_LAST   = 8'hFF;

	// register map
	localparam logic REG_HASH_TYPE = 1'b0;

	// front to back queue
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = 2;
	localparam int QCNT_W      = 3;

	typedef struct packed {
		logic [BYTE_W-1:0] ch;
		logic              last;
		logic [WORD_W-1:0] word;
	} item_t;

endpackage

@@ hdl/cth_table.sv @@
// ----------------------------------------------------------------------------
// cth_table: crypt table memory with its power-up generator
// Fills the table from the generator after reset, then serves one read a cycle.
// ----------------------------------------------------------------------------
module cth_table #(
	parameter int TYPE_COUNT = 5,
	parameter int ADDR_W     = 11
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        rd_en,
	input  logic [ADDR_W-1:0]           rd_addr,
	output logic [cth_pkg::WORD_W-1:0]  rd_data,
	output logic                        busy
);

	localparam int DEPTH = TYPE_COUNT * 256;
	localparam int X_W   = cth_pkg::LCG_W + 3;
	localparam logic [X_W-1:0] MOD_X1 = X_W'(cth_pkg::LCG_MOD);
	localparam logic [X_W-1:0] MOD_X2 = X_W'(2 * cth_pkg::LCG_MOD);
	localparam logic [X_W-1:0] MOD_X3 = X_W'(3 * cth_pkg::LCG_MOD);
	localparam logic [X_W-1:0] MOD_X4 = X_W'(4 * cth_pkg::LCG_MOD);

	logic [cth_pkg::WORD_W-1:0] mem [DEPTH];
	logic [cth_pkg::WORD_W-1:0] rd_data_q;

	logic                        busy_q;
	logic [cth_pkg::LCG_W-1:0]   s_q;
	logic [1:0]                  sub_q;
	logic                        half_q;
	logic [cth_pkg::SECT_W-1:0]  sect_q;
	logic [cth_pkg::BYTE_W-1:0]  idx_q;
	logic [15:0]                 hi_q;

	logic [X_W-1:0]              x5;
	logic [cth_pkg::LCG_W-1:0]   step_val;
	logic                        wr_en;
	logic [10:0]                 wr_addr_full;

	// one times-5 step modulo the generator modulus; add 3 on the last step
	always_comb begin
		x5 = (X_W'(s_q) << 2) + X_W'(s_q)
			+ ((sub_q == cth_pkg::LCG_LAST_SUB) ? X_W'(3) : X_W'(0));
		if (x5 >= MOD_X4) begin
			step_val = cth_pkg::LCG_W'(x5 - MOD_X4);
		end else if (x5 >= MOD_X3) begin
			step_val = cth_pkg::LCG_W'(x5 - MOD_X3);
		end else if (x5 >= MOD_X2) begin
			step_val = cth_pkg::LCG_W'(x5 - MOD_X2);
		end else if (x5 >= MOD_X1) begin
			step_val = cth_pkg::LCG_W'(x5 - MOD_X1);
		end else begin
			step_val = cth_pkg::LCG_W'(x5);
		end
	end

	assign wr_en = busy_q && (sub_q == cth_pkg::LCG_LAST_SUB) && half_q
		&& (sect_q < cth_pkg::SECT_W'(TYPE_COUNT));
	assign wr_addr_full = {sect_q, idx_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
			s_q    <= cth_pkg::LCG_SEED;
			sub_q  <= '0;
			half_q <= 1'b0;
			sect_q <= '0;
			idx_q  <= '0;
		end else if (busy_q) begin
			s_q <= step_val;
			if (sub_q == cth_pkg::LCG_LAST_SUB) begin
				sub_q  <= '0;
				half_q <= !half_q;
				if (half_q) begin
					// sections walk fastest, byte index slowest
					if (sect_q == cth_pkg::SECT_W'(cth_pkg::GEN_SECTIONS - 1)) begin
						sect_q <= '0;
						idx_q  <= idx_q + 1'b1;
						if (idx_q == cth_pkg::INDEX_LAST) begin
							busy_q <= 1'b0;
						end
					end else begin
						sect_q <= sect_q + 1'b1;
					end
				end
			end else begin
				sub_q <= sub_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (busy_q && (sub_q == cth_pkg::LCG_LAST_SUB) && !half_q) begin
			hi_q <= step_val[15:0];
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr_full[ADDR_W-1:0]] <= {hi_q, step_val[15:0]};
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;
	assign busy    = busy_q;

endmodule

@@ hdl/cth_front.sv @@
// ----------------------------------------------------------------------------
// cth_front: byte intake of the crypt table string hash
// Folds case, picks the table section, reads the table and queues the request.
// ----------------------------------------------------------------------------
module cth_front #(
	parameter int TYPE_COUNT = 5,
	parameter int ADDR_W     = 11
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        push,
	output logic                        full,
	input  logic [cth_pkg::BYTE_W-1:0]  key_byte,
	input  logic                        last_byte,
	input  logic [cth_pkg::SECT_W-1:0]  hash_type,
	input  logic                        table_busy,
	input  logic [cth_pkg::QCNT_W-1:0]  q_count,
	output logic                        rd_en,
	output logic [ADDR_W-1:0]           rd_addr,
	input  logic [cth_pkg::WORD_W-1:0]  rd_data,
	output logic                        q_push,
	output cth_pkg::item_t              q_item
);

	logic                        valid_s1;
	logic [cth_pkg::BYTE_W-1:0]  ch_s1;
	logic                        last_s1;

	logic                        accept;
	logic [cth_pkg::BYTE_W-1:0]  ch_fold;
	logic [cth_pkg::SECT_W-1:0]  sect;
	logic [10:0]                 addr_full;
	logic [cth_pkg::QCNT_W:0]    pending;

	// queue slots already spoken for, including the request still in the table read
	assign pending = {1'b0, q_count} + (cth_pkg::QCNT_W+1)'(valid_s1);
	assign full    = table_busy || (pending >= (cth_pkg::QCNT_W+1)'(cth_pkg::QUEUE_DEPTH));
	assign accept  = push && !full;

	always_comb begin
		if ((key_byte >= cth_pkg::CHAR_LOWER_A) && (key_byte <= cth_pkg::CHAR_LOWER_Z)) begin
			ch_fold = key_byte - cth_pkg::CASE_OFFSET;
		end else begin
			ch_fold = key_byte;
		end
		// saturate out-of-range section selects
		if (hash_type >= cth_pkg::SECT_W'(TYPE_COUNT)) begin
			sect = cth_pkg::SECT_W'(TYPE_COUNT - 1);
		end else begin
			sect = hash_type;
		end
	end

	assign addr_full = {sect, ch_fold};
	assign rd_en     = accept;
	assign rd_addr   = addr_full[ADDR_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ch_s1   <= ch_fold;
			last_s1 <= last_byte;
		end
	end

	assign q_push       = valid_s1;
	assign q_item.ch    = ch_s1;
	assign q_item.last  = last_s1;
	assign q_item.word  = rd_data;

endmodule

@@ hdl/cth_queue.sv @@
// ----------------------------------------------------------------------------
// cth_queue: short request queue between intake and seed update
// Four-entry circular buffer of folded bytes with their table words.
// ----------------------------------------------------------------------------
module cth_queue (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        push,
	input  cth_pkg::item_t              push_item,
	input  logic                        pop,
	output logic                        head_valid,
	output cth_pkg::item_t              head_item,
	output logic [cth_pkg::QCNT_W-1:0]  count
);

	cth_pkg::item_t              slot_q [cth_pkg::QUEUE_DEPTH];
	logic [cth_pkg::QPTR_W-1:0]  wr_ptr_q;
	logic [cth_pkg::QPTR_W-1:0]  rd_ptr_q;
	logic [cth_pkg::QCNT_W-1:0]  cnt_q;

	logic do_pop;

	assign head_valid = (cnt_q != '0);
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (!push && do_pop) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_item;
		end
	end

	assign head_item = slot_q[rd_ptr_q];
	assign count     = cnt_q;

`ifndef NO_ASSERTIONS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == cth_pkg::QCNT_W'(cth_pkg::QUEUE_DEPTH)) |-> (!push || do_pop))
		else $error("request queue written while full");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		push |=> (cnt_q != '0))
		else $error("request queue empty right after a write");
`endif

endmodule

@@ hdl/cth_back.sv @@
// ----------------------------------------------------------------------------
// cth_back: seed update and result register of the crypt table string hash
// Folds a request a cycle into the seeds unless a last byte waits; holds hash.
// ----------------------------------------------------------------------------
module cth_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        head_valid,
	input  cth_pkg::item_t              head_item,
	output logic                        q_pop,
	output logic                        empty,
	input  logic                        pop,
	output logic [cth_pkg::WORD_W-1:0]  hash_value
);

	logic [cth_pkg::WORD_W-1:0] first_seed_q;
	logic [cth_pkg::WORD_W-1:0] second_seed_q;
	logic [cth_pkg::WORD_W-1:0] hash_q;
	logic                       out_valid_q;

	logic                       take;
	logic                       out_taken;
	logic [cth_pkg::WORD_W-1:0] first_new;
	logic [cth_pkg::WORD_W-1:0] second_new;

	assign out_taken = pop && out_valid_q;
	// a last byte waits until the result register is free or being drained
	assign take      = head_valid && (!head_item.last || !out_valid_q || pop);
	assign q_pop     = take;

	always_comb begin
		first_new  = head_item.word ^ (first_seed_q + second_seed_q);
		second_new = cth_pkg::WORD_W'(head_item.ch) + first_new + second_seed_q
			+ (second_seed_q << cth_pkg::SEED_SHIFT) + cth_pkg::SEED_INC;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_seed_q  <= cth_pkg::SEED1_INIT;
			second_seed_q <= cth_pkg::SEED2_INIT;
			out_valid_q   <= 1'b0;
		end else begin
			if (take) begin
				if (head_item.last) begin
					first_seed_q  <= cth_pkg::SEED1_INIT;
					second_seed_q <= cth_pkg::SEED2_INIT;
				end else begin
					first_seed_q  <= first_new;
					second_seed_q <= second_new;
				end
			end
			if (take && head_item.last) begin
				out_valid_q <= 1'b1;
			end else if (out_taken) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && head_item.last) begin
			hash_q <= first_new;
		end
	end

	assign empty      = !out_valid_q;
	assign hash_value = hash_q;

`ifndef NO_ASSERTIONS
	a_result_shown: assert property (@(posedge clk) disable iff (!arst_n)
		(take && head_item.last) |=> !empty)
		else $error("finished hash not presented");
	a_seed_reload: assert property (@(posedge clk) disable iff (!arst_n)
		(take && head_item.last) |=> ((first_seed_q == cth_pkg::SEED1_INIT)
			&& (second_seed_q == cth_pkg::SEED2_INIT)))
		else $error("seeds not reloaded after last byte");
`endif

endmodule

@@ hdl/crypt_table_string_hash_core.sv @@
// ----------------------------------------------------------------------------
// crypt_table_string_hash_core: one-way string hash over a crypt table
// Hashes a key a byte a cycle while full is low, then returns its 32-bit hash.
// ----------------------------------------------------------------------------
//  channel   handshake               payload
//  input     push / full             key_byte, last_byte
//  result    pop / empty             hash_value
//  config    APB psel/penable/pwrite paddr, pwdata, prdata (hash_type at 0x0)
//
//  One byte per cycle while full is low; a last byte passes the table read,
//  queue and result register. Seed update (add, xor, add tree) sets that rate.
//  After reset the table generator fills the crypt table, three modulo steps per
//  generator value: full stays high while it fills; config writes are taken.
//  A held result stalls only a key's last byte and the bytes queued behind it.
// ----------------------------------------------------------------------------
module crypt_table_string_hash_core #(
	parameter int TYPE_COUNT = 5
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        push,
	output logic                        full,
	input  logic [cth_pkg::BYTE_W-1:0]  key_byte,
	input  logic                        last_byte,
	output logic                        empty,
	input  logic                        pop,
	output logic [cth_pkg::WORD_W-1:0]  hash_value,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [2:0]                  paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready
);

	localparam int ADDR_W = $clog2(TYPE_COUNT * 256);

	logic [cth_pkg::SECT_W-1:0]  hash_type_q;
	logic                        cfg_write;

	logic                        table_busy;
	logic                        rd_en;
	logic [ADDR_W-1:0]           rd_addr;
	logic [cth_pkg::WORD_W-1:0]  rd_data;

	logic                        q_push;
	cth_pkg::item_t              q_item;
	logic                        q_pop;
	logic                        head_valid;
	cth_pkg::item_t              head_item;
	logic [cth_pkg::QCNT_W-1:0]  q_count;

	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_type_q <= '0;
		end else if (cfg_write && (paddr[2] == cth_pkg::REG_HASH_TYPE)) begin
			hash_type_q <= pwdata[cth_pkg::SECT_W-1:0];
		end
	end

	always_comb begin
		if (paddr[2] == cth_pkg::REG_HASH_TYPE) begin
			prdata = {{(32-cth_pkg::SECT_W){1'b0}}, hash_type_q};
		end else begin
			prdata = '0;
		end
	end

	cth_table #(
		.TYPE_COUNT (TYPE_COUNT),
		.ADDR_W     (ADDR_W)
	) u_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.busy    (table_busy)
	);

	cth_front #(
		.TYPE_COUNT (TYPE_COUNT),
		.ADDR_W     (ADDR_W)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.key_byte   (key_byte),
		.last_byte  (last_byte),
		.hash_type  (hash_type_q),
		.table_busy (table_busy),
		.q_count    (q_count),
		.rd_en      (rd_en),
		.rd_addr    (rd_addr),
		.rd_data    (rd_data),
		.q_push     (q_push),
		.q_item     (q_item)
	);

	cth_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_item  (q_item),
		.pop        (q_pop),
		.head_valid (head_valid),
		.head_item  (head_item),
		.count      (q_count)
	);

	cth_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_item  (head_item),
		.q_pop      (q_pop),
		.empty      (empty),
		.pop        (pop),
		.hash_value (hash_value)
	);

`ifndef NO_ASSERTIONS
	a_fill_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		table_busy |-> full)
		else $error("byte accepted while crypt table is being filled");
`endif

endmodule

@@ sim/crypt_table_string_hash_core_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crypt_table_string_hash_core_tb: self-checking bench for the string hash core
// Streams key bytes through the push/full side under several table sections,
// predicts each key's hash from a local copy of the crypt table and seeds, and
// compares every popped hash in order. Idle and stall bursts on both sides.
// ----------------------------------------------------------------------------
module crypt_table_string_hash_core_tb;

	localparam int          TYPE_COUNT     = 5;
	localparam logic [2:0]  HASH_TYPE_ADDR = 3'(4 * int'(cth_pkg::REG_HASH_TYPE));
	localparam int          SETTLE_CYCLES  = 8;
	localparam int          STALL_LIMIT    = 40000;
	localparam int          PHASE_BYTES    = 230;

	logic                         clk;
	logic                         arst_n;
	logic                         push;
	logic                         full;
	logic [cth_pkg::BYTE_W-1:0]   key_byte;
	logic                         last_byte;
	logic                         empty;
	logic                         pop;
	logic [cth_pkg::WORD_W-1:0]   hash_value;
	logic                         psel;
	logic                         penable;
	logic                         pwrite;
	logic [2:0]                   paddr;
	logic [31:0]                  pwdata;
	logic [31:0]                  prdata;
	logic                         pready;

	// local predictor state
	logic [cth_pkg::WORD_W-1:0]   crypt_words [0:cth_pkg::GEN_SECTIONS*256-1];
	logic [cth_pkg::WORD_W-1:0]   seed_a;
	logic [cth_pkg::WORD_W-1:0]   seed_b;
	logic [2:0]                   table_sel;
	logic [cth_pkg::WORD_W-1:0]   hash_q [$];

	int                  err_count;
	int                  quiet_cycles;
	int                  stall_left;
	bit                  src_gaps;
	bit                  sink_stalls;

	crypt_table_string_hash_core #(
		.TYPE_COUNT(TYPE_COUNT)
	) DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.key_byte   (key_byte),
		.last_byte  (last_byte),
		.empty      (empty),
		.pop        (pop),
		.hash_value (hash_value),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic void build_crypt_words();
		int unsigned s;
		int unsigned hi;
		s = 32'h00100001;
		for (int a = 0; a < 256; a++) begin
			for (int t = 0; t < cth_pkg::GEN_SECTIONS; t++) begin
				s  = (s * 125 + 3) % 32'h2AAAAB;
				hi = s & 32'hFFFF;
				s  = (s * 125 + 3) % 32'h2AAAAB;
				crypt_words[t*256 + a] = {hi[15:0], s[15:0]};
			end
		end
	endfunction

	// advance the seeds by one accepted byte; queue the hash on a last byte
	function automatic void hash_key_byte(input logic [7:0] b, input logic lst);
		logic [7:0]  ch;
		int          sec;
		logic [31:0] w;
		ch = b;
		if (ch >= 8'h61 && ch <= 8'h7A) begin
			ch = ch - 8'h20;
		end
		sec    = (int'(table_sel) >= TYPE_COUNT) ? TYPE_COUNT - 1 : int'(table_sel);
		w      = crypt_words[sec*256 + int'(ch)];
		seed_a = w ^ (seed_a + seed_b);
		seed_b = 32'(ch) + seed_a + seed_b + (seed_b << 5) + 32'd3;
		if (lst) begin
			hash_q.push_back(seed_a);
			seed_a = 32'h7FED7FED;
			seed_b = 32'hEEEEEEEE;
		end
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] exp_v,
			input logic [31:0] got_v);
		$display("%0t mismatch %s: expected %08h got %08h", $realtime, what, exp_v, got_v);
		err_count++;
	endtask

	task automatic send_key_byte(input logic [7:0] b, input logic lst);
		if (src_gaps && $urandom_range(0, 4) == 0) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		push      <= 1'b1;
		key_byte  <= b;
		last_byte <= lst;
		do @(posedge clk); while (full !== 1'b0);
		hash_key_byte(b, lst);
	endtask

	// hold input until every hash is out and the pipeline has emptied
	task automatic wait_idle();
		push <= 1'b0;
		while (hash_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_hash_type(input logic [2:0] t);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= HASH_TYPE_ADDR;
		pwdata  <= {29'($urandom), t};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		table_sel = t;
	endtask

	task automatic test_case_folding();
		write_hash_type(3'd0);
		send_key_byte(8'h61, 1'b1);
		send_key_byte(8'h41, 1'b1);
		send_key_byte(8'h7A, 1'b1);
		send_key_byte(8'h5A, 1'b1);
		send_key_byte(8'h60, 1'b1);
		send_key_byte(8'h7B, 1'b1);
	endtask

	task automatic test_byte_extremes();
		send_key_byte(8'h01, 1'b1);
		send_key_byte(8'hFF, 1'b1);
		send_key_byte(8'h55, 1'b0);
		send_key_byte(8'hAA, 1'b1);
	endtask

	task automatic test_zero_byte();
		send_key_byte(8'h41, 1'b0);
		send_key_byte(8'h00, 1'b0);
		send_key_byte(8'h42, 1'b1);
	endtask

	task automatic test_section_saturation();
		wait_idle();
		write_hash_type(3'd7);
		send_key_byte(8'h61, 1'b1);
		send_key_byte(8'hFF, 1'b1);
		wait_idle();
		write_hash_type(3'd5);
		send_key_byte(8'h61, 1'b1);
	endtask

	// switch the section between bytes of one key
	task automatic test_midkey_select();
		wait_idle();
		write_hash_type(3'd0);
		send_key_byte(8'h48, 1'b0);
		send_key_byte(8'h69, 1'b0);
		wait_idle();
		write_hash_type(3'd3);
		send_key_byte(8'h21, 1'b1);
	endtask

	task automatic test_random_keys();
		logic [2:0] plan [8];
		int         sent;
		int         key_len;
		logic [7:0] b;
		plan = '{3'd0, 3'd7, 3'd2, 3'd4, 3'd5, 3'd1, 3'd6, 3'd3};
		for (int p = 0; p < 8; p++) begin
			wait_idle();
			write_hash_type(plan[p]);
			src_gaps    = (p != 7) && (p % 3 != 1);
			sink_stalls = (p != 7) && (p % 3 != 2);
			sent = 0;
			while (sent < PHASE_BYTES) begin
				key_len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40)
					: $urandom_range(1, 12);
				for (int i = 0; i < key_len; i++) begin
					case ($urandom_range(0, 3))
						0: b = 8'($urandom_range(8'h61, 8'h7A));
						1: b = 8'($urandom_range(8'h41, 8'h5A));
						default: b = 8'($urandom_range(1, 255));
					endcase
					send_key_byte(b, i == key_len - 1);
				end
				sent += key_len;
			end
		end
	endtask

	// result side: pop with stall bursts, check in order, watch for a hang
	always @(posedge clk) begin
		if (arst_n) begin
			if ((push && !full) || (pop && !empty) || (psel && penable)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= STALL_LIMIT) begin
				$display("TB_ERROR");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
			if (pop && !empty) begin
				if (hash_q.size() == 0) begin
					report_mismatch("unexpected hash", 32'h0, hash_value);
				end else begin
					if (hash_value !== hash_q[0]) begin
						report_mismatch("hash_value", hash_q[0], hash_value);
					end
					void'(hash_q.pop_front());
				end
			end
			if (stall_left > 0) begin
				stall_left <= stall_left - 1;
				pop        <= 1'b0;
			end else if (sink_stalls && $urandom_range(0, 5) == 0) begin
				stall_left <= $urandom_range(0, 10);
				pop        <= 1'b0;
			end else begin
				pop <= 1'b1;
			end
		end
	end

	initial begin
		arst_n      <= 1'b0;
		push        <= 1'b0;
		key_byte    <= '0;
		last_byte   <= 1'b0;
		pop         <= 1'b0;
		psel        <= 1'b0;
		penable     <= 1'b0;
		pwrite      <= 1'b0;
		paddr       <= '0;
		pwdata      <= '0;
		err_count    = 0;
		quiet_cycles = 0;
		stall_left   = 0;
		src_gaps     = 1'b1;
		sink_stalls  = 1'b1;
		table_sel    = 3'd0;
		seed_a       = 32'h7FED7FED;
		seed_b       = 32'hEEEEEEEE;
		build_crypt_words();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_case_folding();
		test_byte_extremes();
		test_zero_byte();
		test_section_saturation();
		test_midkey_select();
		test_random_keys();

		push <= 1'b0;
		while (hash_q.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (hash_q.size() != 0) begin
			report_mismatch("hash never returned", hash_q[0], 32'h0);
		end
		if (err_count == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

@@ filelist.f @@
hdl/cth_pkg.sv
hdl/cth_table.sv
hdl/cth_front.sv
hdl/cth_queue.sv
hdl/cth_back.sv
hdl/crypt_table_string_hash_core.sv
sim/crypt_table_string_hash_core_tb.sv
